FILE: rtl/phns_pkg.sv
// ----------------------------------------------------------------------------
// phns_pkg
// Shared types and constants for the hash nonce search block: round
// constants, initial hash words and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package phns_pkg;

   localparam int unsigned RoundCount = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_CHECK,
      ST_DONE
   } state_type;

   // round constant lookup
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // padding words of the single block: 0x80 after byte 16, length 136 bits
   localparam logic [31:0] PadWord = 32'h00800000;
   localparam logic [31:0] LenWord = 32'h00000088;

endpackage
`default_nettype wire

FILE: rtl/puzzle_hash_nonce_search.sv
// ----------------------------------------------------------------------------
// puzzle_hash_nonce_search
// SHA-256 proof-of-work hash of one nonce, or a search for the first nonce
// whose folded digest lies below a limit.
// ----------------------------------------------------------------------------
// One shared SHA-256 round unit with a rolling 16-word schedule window does
// one compression round per cycle. Each nonce passes through one load, 64
// rounds, one final add and one fold and compare. A search tries up to
// 2^32-1 nonces, and shows its result straight after the load when the
// limit is zero. The block takes no new item while an item is in flight or
// its result waits, and is ready again once the result is taken and the
// sequencer has returned from DONE to IDLE.
`default_nettype none
module puzzle_hash_nonce_search
   import phns_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // nonce[31:0], limit[63:32], challenge[95:64], peer_address[127:96],
   // peer_port[159:128], kind[167:160]
   input  wire logic [167:0] req_tdata,
   // op[0]
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // folded_hash[31:0], found_nonce[63:32]
   output logic [63:0]       rsp_tdata,
   // found[0]
   output logic              rsp_tuser
);

   state_type state_ff, state_in;

   logic        op_ff;
   logic [31:0] nonce_ff, limit_ff, chal_ff, addr_ff, port_ff;
   logic [7:0]  kind_ff;
   logic [31:0] w_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [31:0] hv_ff [8];
   logic [5:0]  rnd_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_found_ff;
   logic        rsp_valid_ff;

   function automatic logic [31:0] bswap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // round datapath
   logic [31:0] t1, t2, s0w, s1w, w_new;
   always_comb begin
      t1 = h_ff + (rotr(e_ff, 6) ^ rotr(e_ff, 11) ^ rotr(e_ff, 25))
         + ((e_ff & f_ff) ^ (~e_ff & g_ff)) + round_k(rnd_ff) + w_ff[0];
      t2 = (rotr(a_ff, 2) ^ rotr(a_ff, 13) ^ rotr(a_ff, 22))
         + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
      s0w = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0w + w_ff[9] + s1w;
   end

   // digest fold: xor of the eight bytes of each pair of words
   logic [31:0] fold_in;
   always_comb begin
      logic [31:0] x;
      for (int k = 0; k < 4; k++) begin
         x = hv_ff[2*k] ^ hv_ff[2*k+1];
         fold_in[31-8*k -: 8] = x[31:24] ^ x[23:16] ^ x[15:8] ^ x[7:0];
      end
   end

   // digest words are settled during the check cycle
   logic hit;
   assign hit = fold_in < limit_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_LOAD;
         ST_LOAD:  state_in = (op_ff && limit_ff == 32'd0) ? ST_DONE : ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'(RoundCount - 1)) state_in = ST_FINAL;
         ST_FINAL: state_in = ST_CHECK;
         ST_CHECK: begin
            if (!op_ff || hit || nonce_ff == 32'hffffffff) state_in = ST_DONE;
            else state_in = ST_LOAD;
         end
         ST_DONE:  if (!rsp_valid_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            op_ff    <= req_tuser;
            nonce_ff <= req_tuser ? 32'd1 : req_tdata[31:0];
            limit_ff <= req_tdata[63:32];
            chal_ff  <= req_tdata[95:64];
            addr_ff  <= req_tdata[127:96];
            port_ff  <= req_tdata[159:128];
            kind_ff  <= req_tdata[167:160];
         end
         ST_LOAD: begin
            w_ff[0] <= bswap(nonce_ff);
            w_ff[1] <= bswap(chal_ff);
            w_ff[2] <= bswap(addr_ff);
            w_ff[3] <= bswap(port_ff);
            w_ff[4] <= {kind_ff, PadWord[23:0]};
            for (int i = 5; i < 15; i++) w_ff[i] <= 32'd0;
            w_ff[15] <= LenWord;
            {a_ff, b_ff, c_ff, d_ff} <= {InitH[0], InitH[1], InitH[2], InitH[3]};
            {e_ff, f_ff, g_ff, h_ff} <= {InitH[4], InitH[5], InitH[6], InitH[7]};
            rnd_ff <= 6'd0;
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= w_new;
            h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
            d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
            rnd_ff <= rnd_ff + 6'd1;
         end
         ST_FINAL: begin
            hv_ff[0] <= InitH[0] + a_ff; hv_ff[1] <= InitH[1] + b_ff;
            hv_ff[2] <= InitH[2] + c_ff; hv_ff[3] <= InitH[3] + d_ff;
            hv_ff[4] <= InitH[4] + e_ff; hv_ff[5] <= InitH[5] + f_ff;
            hv_ff[6] <= InitH[6] + g_ff; hv_ff[7] <= InitH[7] + h_ff;
         end
         ST_CHECK: begin
            if (op_ff && !hit && nonce_ff != 32'hffffffff) nonce_ff <= nonce_ff + 32'd1;
         end
         default: ;
      endcase
   end

   // result register
   logic load_rsp;
   assign load_rsp = (state_ff == ST_LOAD && op_ff && limit_ff == 32'd0)
                   || (state_ff == ST_CHECK
                       && (!op_ff || hit || nonce_ff == 32'hffffffff));

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (state_ff == ST_LOAD || (op_ff && !hit)) begin
            rsp_data_ff  <= 64'd0;
            rsp_found_ff <= 1'b0;
         end else begin
            rsp_data_ff  <= {op_ff ? nonce_ff : 32'd0, fold_in};
            rsp_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (load_rsp) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule
`default_nettype wire

FILE: rtl/phns_checker.sv
// ----------------------------------------------------------------------------
// phns_checker
// Port-level checks for the hash nonce search block.
// ----------------------------------------------------------------------------
`default_nettype none
module phns_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata,
   input wire logic         rsp_tuser
);

   // no new item while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");

   // an accepted item blocks further items next cycle
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");

   // a miss carries zero payload
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 64'd0) else $error("miss payload");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

endmodule

bind puzzle_hash_nonce_search phns_checker u_phns_checker (.*);
`default_nettype wire
